// ===== sv/nvq_pkg.sv =====
// Shared constants, widths and controller/datapath command types for the
// normal vector byte quantizer. No dependencies.
`default_nettype none

package nvq_pkg;

   localparam int VEC_W  = 16;   // input component, signed Q2.13
   localparam int CODE_W = 8;    // output byte code
   localparam int TOL_W  = 16;   // length tolerance, unsigned Q0.16

   localparam logic [TOL_W-1:0] TOL_RESET = 16'd1966;

   localparam int SEARCH_RADIUS = 2;

   localparam int RAD_W  = 58;   // square-root radicand
   localparam int ROOT_W = 29;   // square-root result
   localparam int NUM_W  = 59;   // divider dividend / quotient
   localparam int DEN_W  = 29;   // divider divisor
   localparam int NRM_W  = 32;   // normalised component, signed Q1.30
   localparam int ACC_W  = 42;   // shared sum of products
   localparam int ERR_W  = 36;   // candidate score

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ_ACC,
      OP_ACC_CLR,
      OP_SET_ZERO,
      OP_SQRT_LEN,
      OP_NDIV_START,
      OP_N_STORE,
      OP_CSQ_ACC,
      OP_SQRT_CAND,
      OP_DOT_ACC,
      OP_DDIV_START,
      OP_SCORE,
      OP_ADVANCE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic zero;
      logic sq_done;
      logic div_done;
      logic pass;
      logic last;
      logic rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

// ===== sv/nvq_req_if.sv =====
// Input channel: valid/ready handshake carrying one vector word.
// Depends on nvq_pkg.
`default_nettype none

interface nvq_req_if import nvq_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [VEC_W-1:0] vec_x;
   logic signed [VEC_W-1:0] vec_y;
   logic signed [VEC_W-1:0] vec_z;

   modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
   modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

`default_nettype wire

// ===== sv/nvq_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one byte-code word.
// Depends on nvq_pkg.
`default_nettype none

interface nvq_rsp_if import nvq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code_r;
   logic [CODE_W-1:0] code_g;
   logic [CODE_W-1:0] code_b;

   modport source (output valid, output code_r, output code_g, output code_b, input ready);
   modport sink   (input valid, input code_r, input code_g, input code_b, output ready);
endinterface

`default_nettype wire

// ===== sv/nvq_sqrt.sv =====
// Iterative integer square root, one result bit per cycle (floor).
// Depends on nvq_pkg.
`default_nettype none

module nvq_sqrt import nvq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [RAD_W-1:0]  radicand,
   output logic      [ROOT_W-1:0] root,
   output logic                   done
);

   localparam int STEPS = RAD_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [ROOT_W+3:0] rem_sh;
   logic [ROOT_W+3:0] trial;
   logic [ROOT_W+3:0] diff;
   logic              take;

   assign rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign diff   = rem_sh - trial;
   assign take   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (take) begin
            rem_ff  <= diff[ROOT_W+1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[ROOT_W+1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// ===== sv/nvq_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nvq_pkg.
`default_nettype none

module nvq_div import nvq_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic      [NUM_W-1:0] quot,
   output logic                  done
);

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;
   logic             take;

   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign take   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   // dividend bits leave at the top while quotient bits enter at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], take};
         rem_ff <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end
   end

   assign quot = num_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// ===== sv/nvq_ctrl.sv =====
// Sequencer: steps the datapath through normalise, pack and candidate search.
// Depends on nvq_pkg.
`default_nettype none

module nvq_ctrl import nvq_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_SQ, S_ZCHK, S_LEN, S_NSTART, S_NDIV, S_CAND, S_CSQ,
      S_CSQRT, S_CWAIT, S_DOT, S_DDIV, S_DWAIT, S_NEXT, S_OUT
   } state_type;

   state_type  state_ff;
   logic [1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= 2'd0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_SQ;
                  idx_ff   <= 2'd0;
               end
            end
            S_SQ: begin
               if (idx_ff == 2'd2) begin
                  state_ff <= S_ZCHK;
                  idx_ff   <= 2'd0;
               end else begin
                  idx_ff <= idx_ff + 2'd1;
               end
            end
            S_ZCHK:   state_ff <= stat.zero ? S_OUT : S_LEN;
            S_LEN:    if (stat.sq_done) state_ff <= S_NDIV;
            S_NSTART: state_ff <= S_NDIV;
            S_NDIV: begin
               if (stat.div_done) begin
                  if (idx_ff == 2'd2) begin
                     state_ff <= S_CAND;
                     idx_ff   <= 2'd0;
                  end else begin
                     state_ff <= S_NSTART;
                     idx_ff   <= idx_ff + 2'd1;
                  end
               end
            end
            S_CAND: begin
               state_ff <= S_CSQ;
               idx_ff   <= 2'd0;
            end
            S_CSQ: begin
               if (idx_ff == 2'd2) begin
                  state_ff <= S_CSQRT;
                  idx_ff   <= 2'd0;
               end else begin
                  idx_ff <= idx_ff + 2'd1;
               end
            end
            S_CSQRT:  state_ff <= S_CWAIT;
            S_CWAIT: begin
               if (stat.sq_done) begin
                  state_ff <= stat.pass ? S_DOT : S_NEXT;
                  idx_ff   <= 2'd0;
               end
            end
            S_DOT: begin
               if (idx_ff == 2'd2) begin
                  state_ff <= S_DDIV;
                  idx_ff   <= 2'd0;
               end else begin
                  idx_ff <= idx_ff + 2'd1;
               end
            end
            S_DDIV:   state_ff <= S_DWAIT;
            S_DWAIT:  if (stat.div_done) state_ff <= S_NEXT;
            S_NEXT:   state_ff <= stat.last ? S_OUT : S_CAND;
            S_OUT:    if (!stat.rsp_busy) state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.op    = OP_NONE;
      cmd.idx   = idx_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         S_SQ:     cmd.op = OP_SQ_ACC;
         S_ZCHK:   cmd.op = stat.zero ? OP_SET_ZERO : OP_SQRT_LEN;
         S_LEN:    if (stat.sq_done) cmd.op = OP_NDIV_START;
         S_NSTART: cmd.op = OP_NDIV_START;
         S_NDIV:   if (stat.div_done) cmd.op = OP_N_STORE;
         S_CAND:   cmd.op = OP_ACC_CLR;
         S_CSQ:    cmd.op = OP_CSQ_ACC;
         S_CSQRT:  cmd.op = OP_SQRT_CAND;
         S_CWAIT:  if (stat.sq_done && stat.pass) cmd.op = OP_ACC_CLR;
         S_DOT:    cmd.op = OP_DOT_ACC;
         S_DDIV:   cmd.op = OP_DDIV_START;
         S_DWAIT:  if (stat.div_done) cmd.op = OP_SCORE;
         S_NEXT:   if (!stat.last) cmd.op = OP_ADVANCE;
         S_OUT:    if (!stat.rsp_busy) cmd.op = OP_EMIT;
         default:  cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/nvq_dp.sv =====
// Datapath: operand registers, shared multiplier, square-root and divider units,
// candidate cursor, best-score tracking and output word. Depends on nvq_pkg.
`default_nettype none

module nvq_dp import nvq_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output stat_type                     stat,
   input  wire logic signed [VEC_W-1:0] vec_x,
   input  wire logic signed [VEC_W-1:0] vec_y,
   input  wire logic signed [VEC_W-1:0] vec_z,
   input  wire logic                    csr_wr_en,
   input  wire logic [TOL_W-1:0]        csr_wr_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [CODE_W-1:0]            code_r,
   output logic [CODE_W-1:0]            code_g,
   output logic [CODE_W-1:0]            code_b
);

   localparam logic [CODE_W-1:0] RAD   = CODE_W'(SEARCH_RADIUS);
   localparam logic [CODE_W-1:0] MAXB  = '1;
   localparam logic [CODE_W-1:0] MIDB  = 8'd128;

   logic signed [VEC_W-1:0]  vec_ff [3];
   logic signed [NRM_W-1:0]  n_ff   [3];
   logic [CODE_W-1:0]        lo_ff  [3];
   logic [CODE_W-1:0]        hi_ff  [3];
   logic [CODE_W-1:0]        cur_ff [3];
   logic [CODE_W-1:0]        best_ff[3];
   logic [CODE_W-1:0]        out_ff [3];
   logic signed [ACC_W-1:0]  acc_ff;
   logic [ERR_W-1:0]         best_e_ff;
   logic                     found_ff;
   logic                     neg_ff;
   logic [TOL_W-1:0]         tol_ff;
   logic                     rsp_valid_ff;

   logic signed [VEC_W-1:0]  d [3];
   logic signed [NRM_W-1:0]  mul_a;
   logic signed [VEC_W-1:0]  mul_b;
   logic signed [NRM_W+VEC_W-1:0] prod;
   logic signed [VEC_W-1:0]  vsel;
   logic [VEC_W-1:0]         vabs;
   logic [ACC_W-1:0]         acc_abs;

   logic                     sq_start, sq_done;
   logic [RAD_W-1:0]         sq_rad;
   logic [ROOT_W-1:0]        sq_root;
   logic                     div_start, div_done;
   logic [NUM_W-1:0]         div_num;
   logic [NUM_W-1:0]         div_quot;

   logic signed [NRM_W-1:0]  n_new;
   logic [NRM_W-1:0]         n_bias;
   logic [NRM_W+7:0]         t_pack;
   logic [CODE_W:0]          b9;
   logic [CODE_W-1:0]        start_b;
   logic [CODE_W-1:0]        lo_b, hi_b;

   logic [ROOT_W:0]          a_lim, b_lim, lo_r, hi_r, root_x;
   logic                     pass;

   logic signed [ERR_W-1:0]  dot, dot_err;
   logic [ERR_W-1:0]         e_abs;
   logic                     last;

   for (genvar i = 0; i < 3; i++) begin : g_dec
      assign d[i] = $signed({7'd0, cur_ff[i], 1'b0}) - 16'sd255;
   end

   assign vsel = vec_ff[cmd.idx];
   assign vabs = vsel[VEC_W-1] ? VEC_W'(-vsel) : vsel;
   assign acc_abs = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;

   always_comb begin
      case (cmd.op)
         OP_SQ_ACC: begin
            mul_a = NRM_W'(vsel);
            mul_b = vsel;
         end
         OP_CSQ_ACC: begin
            mul_a = NRM_W'(d[cmd.idx]);
            mul_b = d[cmd.idx];
         end
         OP_DOT_ACC: begin
            mul_a = n_ff[cmd.idx];
            mul_b = d[cmd.idx];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   // length of input in Q.26, candidate radius in Q.16
   assign sq_start = (cmd.op == OP_SQRT_LEN) || (cmd.op == OP_SQRT_CAND);
   assign sq_rad   = (cmd.op == OP_SQRT_LEN) ? {acc_ff[31:0], 26'd0}
                                             : {8'd0, acc_ff[17:0], 32'd0};

   assign div_start = (cmd.op == OP_NDIV_START) || (cmd.op == OP_DDIV_START);
   assign div_num   = (cmd.op == OP_NDIV_START) ? {vabs, 43'd0}
                                                : {1'b0, acc_abs, 16'd0};

   nvq_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .root     (sq_root),
      .done     (sq_done)
   );

   nvq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (sq_root),
      .quot     (div_quot),
      .done     (div_done)
   );

   // normalised component and its direct byte packing
   assign n_new   = vsel[VEC_W-1] ? -$signed(div_quot[NRM_W-1:0])
                                  : $signed(div_quot[NRM_W-1:0]);
   assign n_bias  = NRM_W'(n_new + 32'sd1073741824);
   assign t_pack  = ({n_bias, 8'd0} - {8'd0, n_bias}) + 40'h0040000000;
   assign b9      = t_pack[NRM_W+7 -: CODE_W+1];
   assign start_b = b9[CODE_W] ? MAXB : b9[CODE_W-1:0];
   assign lo_b    = (start_b < RAD) ? '0 : start_b - RAD;
   assign hi_b    = (start_b > MAXB - RAD) ? MAXB : start_b + RAD;

   // floor(r/255) within tol of one, tested on r itself
   assign a_lim  = (ROOT_W+1)'(17'h10000 - {1'b0, tol_ff});
   assign b_lim  = (ROOT_W+1)'(18'h10000) + (ROOT_W+1)'(tol_ff);
   assign lo_r   = (a_lim << 8) - a_lim;
   assign hi_r   = (b_lim << 8) - b_lim + (ROOT_W+1)'(254);
   assign root_x = {1'b0, sq_root};
   assign pass   = (root_x >= lo_r) && (root_x <= hi_r);

   assign dot     = neg_ff ? -$signed({2'b00, div_quot[ERR_W-3:0]})
                           : $signed({2'b00, div_quot[ERR_W-3:0]});
   assign dot_err = dot - 36'sd1073741824;
   assign e_abs   = dot_err[ERR_W-1] ? ERR_W'(-dot_err) : dot_err;

   assign last = (cur_ff[0] == hi_ff[0]) && (cur_ff[1] == hi_ff[1]) &&
                 (cur_ff[2] == hi_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) tol_ff <= csr_wr_data;
         if (cmd.op == OP_EMIT) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.op == OP_LOAD) found_ff <= 1'b0;
         else if (cmd.op == OP_SCORE) found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            vec_ff[0] <= vec_x;
            vec_ff[1] <= vec_y;
            vec_ff[2] <= vec_z;
            acc_ff    <= '0;
         end
         OP_SQ_ACC, OP_CSQ_ACC, OP_DOT_ACC: acc_ff <= acc_ff + ACC_W'(prod);
         OP_ACC_CLR: acc_ff <= '0;
         OP_SET_ZERO: begin
            best_ff[0] <= MIDB;
            best_ff[1] <= MIDB;
            best_ff[2] <= MIDB;
         end
         OP_N_STORE: begin
            n_ff[cmd.idx]    <= n_new;
            lo_ff[cmd.idx]   <= lo_b;
            hi_ff[cmd.idx]   <= hi_b;
            cur_ff[cmd.idx]  <= lo_b;
            best_ff[cmd.idx] <= start_b;
         end
         OP_DDIV_START: neg_ff <= acc_ff[ACC_W-1];
         OP_SCORE: begin
            if (!found_ff || (e_abs < best_e_ff)) begin
               best_e_ff <= e_abs;
               best_ff   <= cur_ff;
            end
         end
         OP_ADVANCE: begin
            // z fastest, then y, then x
            if (cur_ff[2] != hi_ff[2]) begin
               cur_ff[2] <= cur_ff[2] + 1'b1;
            end else begin
               cur_ff[2] <= lo_ff[2];
               if (cur_ff[1] != hi_ff[1]) begin
                  cur_ff[1] <= cur_ff[1] + 1'b1;
               end else begin
                  cur_ff[1] <= lo_ff[1];
                  cur_ff[0] <= cur_ff[0] + 1'b1;
               end
            end
         end
         OP_EMIT: out_ff <= best_ff;
         default: ;
      endcase
   end

   assign stat.zero     = (acc_ff == '0);
   assign stat.sq_done  = sq_done;
   assign stat.div_done = div_done;
   assign stat.pass     = pass;
   assign stat.last     = last;
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign code_r    = out_ff[0];
   assign code_g    = out_ff[1];
   assign code_b    = out_ff[2];

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten while still waiting");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SQRT_LEN) |-> (acc_ff != '0))
      else $error("normalising a zero vector");

   a_score_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SCORE) |=> found_ff)
      else $error("score taken but no best recorded");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_ADVANCE) |=> (cur_ff[2] >= lo_ff[2] && cur_ff[2] <= hi_ff[2]))
      else $error("candidate cursor left its window");
`endif

endmodule

`default_nettype wire

// ===== sv/normal_vector_byte_quantizer.sv =====
// Top level of the normal vector byte quantizer: sequencer plus datapath.
// Depends on nvq_pkg, nvq_req_if, nvq_rsp_if, nvq_ctrl, nvq_dp.
//
//   channel   dir  handshake           word
//   req_word  in   valid/ready         vec_x, vec_y, vec_z (signed Q2.13)
//   rsp_word  out  valid/ready         code_r, code_g, code_b
//   csr_*     in   csr_wr_en strobe    length_tolerance (Q0.16)
//
// One vector at a time: normalise and pack it, then test each of up to 125
// candidates and score the accepted ones; the square root is bit-serial
// (29 steps) and so is the divider (59 steps).
// A zero vector skips normalisation and the search. Reset is synchronous and needs no sweep.
// A new vector is taken while the previous result word still waits on rsp_word.
`default_nettype none

module normal_vector_byte_quantizer import nvq_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   nvq_req_if.sink               req_word,
   nvq_rsp_if.source             rsp_word,
   input  wire logic             csr_wr_en,
   input  wire logic [TOL_W-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   nvq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_word.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nvq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .vec_x       (req_word.vec_x),
      .vec_y       (req_word.vec_y),
      .vec_z       (req_word.vec_z),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_word.valid),
      .rsp_ready   (rsp_word.ready),
      .code_r      (rsp_word.code_r),
      .code_g      (rsp_word.code_g),
      .code_b      (rsp_word.code_b)
   );

   assign req_word.ready = req_ready;

endmodule

`default_nettype wire
